@@ src/apsat_pkg.sv @@
// ----------------------------------------------------------------------------
// apsat_pkg: shared types and codes of the AP / station association table
// Command and result transaction types, operation and status codes, and the
// classified job record that travels from the front end to the table engine.
// ----------------------------------------------------------------------------
package apsat_pkg;

	localparam int DEFAULT_MAX_APS  = 16;
	localparam int DEFAULT_MAX_STAS = 8;

	localparam logic [7:0] NO_CHANNEL = 8'd255;

	// operation codes
	localparam logic [1:0] OP_BEACON = 2'd0;
	localparam logic [1:0] OP_DATA   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// DS status codes
	localparam logic [1:0] DS_TO   = 2'd1;
	localparam logic [1:0] DS_FROM = 2'd2;

	// result status codes
	localparam logic [3:0] ST_AP_NEW    = 4'd0;
	localparam logic [3:0] ST_AP_UPD    = 4'd1;
	localparam logic [3:0] ST_STA_NEW   = 4'd2;
	localparam logic [3:0] ST_STA_UPD   = 4'd3;
	localparam logic [3:0] ST_FULL      = 4'd4;
	localparam logic [3:0] ST_IGNORED   = 4'd5;
	localparam logic [3:0] ST_READ_OK   = 4'd6;
	localparam logic [3:0] ST_BAD_INDEX = 4'd7;
	localparam logic [3:0] ST_CLEARED   = 4'd8;

	typedef struct packed {
		logic [1:0]        operation;
		logic [47:0]       addr_one;
		logic [47:0]       addr_two;
		logic [47:0]       addr_three;
		logic [1:0]        ds_bits;
		logic signed [7:0] rssi;
		logic [7:0]        channel;
		logic [5:0]        ssid_length;
		logic              rsn_present;
		logic [3:0]        read_index;
	} cmd_t;

	typedef struct packed {
		logic [3:0]        status;
		logic [3:0]        ap_slot;
		logic [2:0]        sta_slot;
		logic [4:0]        ap_total;
		logic [47:0]       entry_bssid;
		logic [7:0]        entry_channel;
		logic signed [7:0] entry_rssi;
		logic [3:0]        entry_sta_total;
	} result_t;

	typedef enum logic [2:0] {
		JOB_IGNORE = 3'd0,
		JOB_BEACON = 3'd1,
		JOB_DATA   = 3'd2,
		JOB_READ   = 3'd3,
		JOB_CLEAR  = 3'd4
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic [47:0]       ap_mac;
		logic [47:0]       sta_mac;
		logic signed [7:0] rssi;
		logic [7:0]        channel;
		logic              new_ok;
		logic [3:0]        read_index;
	} job_t;

endpackage

@@ src/apsat_front.sv @@
// ----------------------------------------------------------------------------
// apsat_front: command intake and classification
// Decodes each command transaction into a job (AP and station keys picked
// from the DS bits, ignore cases resolved) and queues it for the engine.
// ----------------------------------------------------------------------------
module apsat_front
	import apsat_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic job_valid,
	input  logic job_pop,
	output job_t job
);

	localparam int Q_DEPTH = 2;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int FILL_W  = $clog2(Q_DEPTH + 1);

	job_t              queue_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	job_t              new_job;
	logic              push;

	always_comb begin
		new_job            = '0;
		new_job.kind       = JOB_IGNORE;
		new_job.rssi       = cmd.rssi;
		new_job.channel    = cmd.channel;
		new_job.new_ok     = (cmd.channel != NO_CHANNEL) && cmd.rsn_present;
		new_job.read_index = cmd.read_index;
		case (cmd.operation)
			OP_BEACON: begin
				new_job.ap_mac = cmd.addr_three;
				new_job.kind   = (cmd.ssid_length == 6'd0) ? JOB_IGNORE : JOB_BEACON;
			end
			OP_DATA: begin
				if (cmd.ds_bits == DS_TO) begin
					new_job.kind    = JOB_DATA;
					new_job.ap_mac  = cmd.addr_one;
					new_job.sta_mac = cmd.addr_two;
				end else if (cmd.ds_bits == DS_FROM) begin
					new_job.kind    = JOB_DATA;
					new_job.ap_mac  = cmd.addr_two;
					new_job.sta_mac = cmd.addr_three;
				end
			end
			OP_READ:  new_job.kind = JOB_READ;
			OP_CLEAR: new_job.kind = JOB_CLEAR;
			default:  new_job.kind = JOB_IGNORE;
		endcase
	end

	assign busy      = (fill_q == FILL_W'(Q_DEPTH));
	assign push      = start && !busy;
	assign job_valid = (fill_q != '0);
	assign job       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (job_pop && job_valid) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !(job_pop && job_valid)) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (!push && job_pop && job_valid) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

@@ src/apsat_back.sv @@
// ----------------------------------------------------------------------------
// apsat_back: table engine
// Sequencer that scans the AP table and then the station list of one AP,
// one entry per cycle over registered memory reads, and updates or appends.
// ----------------------------------------------------------------------------
module apsat_back
	import apsat_pkg::*;
#(
	parameter int MAX_APS  = DEFAULT_MAX_APS,
	parameter int MAX_STAS = DEFAULT_MAX_STAS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    job_valid,
	input  job_t    job,
	output logic    job_pop,
	output logic    done,
	output result_t result
);

	localparam int AP_IDX_W   = (MAX_APS > 1) ? $clog2(MAX_APS) : 1;
	localparam int AP_CNT_W   = $clog2(MAX_APS + 1);
	localparam int STA_IDX_W  = (MAX_STAS > 1) ? $clog2(MAX_STAS) : 1;
	localparam int STA_CNT_W  = $clog2(MAX_STAS + 1);
	localparam int STA_DEPTH  = MAX_APS * MAX_STAS;
	localparam int STA_ADDR_W = (STA_DEPTH > 1) ? $clog2(STA_DEPTH) : 1;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_AP_SCAN  = 6'b000010,
		S_AP_ADD   = 6'b000100,
		S_STA_SCAN = 6'b001000,
		S_STA_ADD  = 6'b010000,
		S_READ     = 6'b100000
	} state_t;

	// table storage
	logic [47:0]          ap_bssid_mem [MAX_APS];
	logic [7:0]           ap_chan_mem  [MAX_APS];
	logic signed [7:0]    ap_rssi_mem  [MAX_APS];
	logic [STA_CNT_W-1:0] sta_cnt_mem  [MAX_APS];
	logic [47:0]          sta_mac_mem  [STA_DEPTH];
	logic signed [7:0]    sta_rssi_mem [STA_DEPTH];

	state_t                state_q;
	job_t                  cur_q;
	logic [AP_CNT_W-1:0]   ap_count_q;
	logic [AP_IDX_W-1:0]   scan_ptr_q;
	logic [AP_IDX_W-1:0]   ap_sel_q;
	logic [STA_CNT_W-1:0]  sta_n_q;
	logic [STA_ADDR_W-1:0] sta_base_q;
	logic [STA_IDX_W-1:0]  sta_ptr_q;
	logic                  done_q;
	result_t               result_q;

	// registered read side
	logic [AP_IDX_W-1:0]   ap_rd_idx_s1;
	logic                  ap_rd_vld_s1;
	logic [47:0]           ap_bssid_rd_s1;
	logic [7:0]            ap_chan_rd_s1;
	logic signed [7:0]     ap_rssi_rd_s1;
	logic [STA_CNT_W-1:0]  sta_cnt_rd_s1;
	logic [STA_IDX_W-1:0]  sta_rd_idx_s1;
	logic                  sta_rd_vld_s1;
	logic [47:0]           sta_mac_rd_s1;

	logic                  ap_hit, ap_last, ap_full;
	logic                  sta_hit, sta_last, sta_full;
	logic                  read_bad;
	logic [AP_IDX_W-1:0]   ap_raddr;
	logic [STA_ADDR_W-1:0] sta_raddr;
	logic                  ap_new_we, ap_rssi_we, sta_cnt_we, sta_new_we, sta_rssi_we;
	logic [AP_IDX_W-1:0]   ap_rssi_waddr, sta_cnt_waddr;
	logic [STA_CNT_W-1:0]  sta_cnt_wdata;
	logic [STA_ADDR_W-1:0] sta_new_waddr, sta_rssi_waddr;

	assign ap_hit   = ap_rd_vld_s1 && (ap_bssid_rd_s1 == cur_q.ap_mac);
	assign ap_last  = ap_rd_vld_s1 && (32'(ap_rd_idx_s1) == 32'(ap_count_q) - 32'd1);
	assign ap_full  = 32'(ap_count_q) >= MAX_APS;
	assign sta_hit  = sta_rd_vld_s1 && (sta_mac_rd_s1 == cur_q.sta_mac);
	assign sta_last = sta_rd_vld_s1 && (32'(sta_rd_idx_s1) == 32'(sta_n_q) - 32'd1);
	assign sta_full = 32'(sta_n_q) >= MAX_STAS;
	assign read_bad = 32'(job.read_index) >= 32'(ap_count_q);

	assign job_pop  = (state_q == S_IDLE) && job_valid;

	assign ap_raddr  = (state_q == S_IDLE) ? AP_IDX_W'(job.read_index) : scan_ptr_q;
	assign sta_raddr = sta_base_q + STA_ADDR_W'(sta_ptr_q);

	// write controls
	assign ap_new_we   = (state_q == S_AP_ADD) && (cur_q.kind == JOB_BEACON) &&
	                     cur_q.new_ok && !ap_full;
	assign ap_rssi_we  = ap_new_we ||
	                     ((state_q == S_AP_SCAN) && (cur_q.kind == JOB_BEACON) && ap_hit);
	assign ap_rssi_waddr = ap_new_we ? AP_IDX_W'(ap_count_q) : ap_rd_idx_s1;
	assign sta_new_we  = (state_q == S_STA_ADD) && !sta_full;
	assign sta_cnt_we  = ap_new_we || sta_new_we;
	assign sta_cnt_waddr = ap_new_we ? AP_IDX_W'(ap_count_q) : ap_sel_q;
	assign sta_cnt_wdata = ap_new_we ? '0 : sta_n_q + STA_CNT_W'(1);
	assign sta_new_waddr = sta_base_q + STA_ADDR_W'(sta_n_q);
	assign sta_rssi_we = sta_new_we || ((state_q == S_STA_SCAN) && sta_hit);
	assign sta_rssi_waddr = sta_new_we ? sta_new_waddr :
	                        sta_base_q + STA_ADDR_W'(sta_rd_idx_s1);

	always_ff @(posedge clk) begin
		if (ap_new_we) begin
			ap_bssid_mem[AP_IDX_W'(ap_count_q)] <= cur_q.ap_mac;
			ap_chan_mem[AP_IDX_W'(ap_count_q)]  <= cur_q.channel;
		end
		if (ap_rssi_we) begin
			ap_rssi_mem[ap_rssi_waddr] <= cur_q.rssi;
		end
		if (sta_cnt_we) begin
			sta_cnt_mem[sta_cnt_waddr] <= sta_cnt_wdata;
		end
		if (sta_new_we) begin
			sta_mac_mem[sta_new_waddr] <= cur_q.sta_mac;
		end
		if (sta_rssi_we) begin
			sta_rssi_mem[sta_rssi_waddr] <= cur_q.rssi;
		end
		ap_bssid_rd_s1 <= ap_bssid_mem[ap_raddr];
		ap_chan_rd_s1  <= ap_chan_mem[ap_raddr];
		ap_rssi_rd_s1  <= ap_rssi_mem[ap_raddr];
		sta_cnt_rd_s1  <= sta_cnt_mem[ap_raddr];
		sta_mac_rd_s1  <= sta_mac_mem[sta_raddr];
		ap_rd_idx_s1   <= scan_ptr_q;
		sta_rd_idx_s1  <= sta_ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cur_q         <= '0;
			ap_count_q    <= '0;
			scan_ptr_q    <= '0;
			ap_sel_q      <= '0;
			sta_n_q       <= '0;
			sta_base_q    <= '0;
			sta_ptr_q     <= '0;
			ap_rd_vld_s1  <= 1'b0;
			sta_rd_vld_s1 <= 1'b0;
			done_q        <= 1'b0;
			result_q      <= '0;
		end else begin
			done_q        <= 1'b0;
			// read data is a scan compare only if its address came from a scan cycle
			ap_rd_vld_s1  <= (state_q == S_AP_SCAN);
			sta_rd_vld_s1 <= (state_q == S_STA_SCAN);
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						cur_q      <= job;
						scan_ptr_q <= '0;
						case (job.kind)
							JOB_BEACON, JOB_DATA: begin
								state_q <= (ap_count_q == '0) ? S_AP_ADD : S_AP_SCAN;
							end
							JOB_READ: begin
								if (read_bad) begin
									done_q            <= 1'b1;
									result_q          <= '0;
									result_q.status   <= ST_BAD_INDEX;
									result_q.ap_slot  <= job.read_index;
									result_q.ap_total <= 5'(ap_count_q);
								end else begin
									state_q <= S_READ;
								end
							end
							JOB_CLEAR: begin
								ap_count_q      <= '0;
								done_q          <= 1'b1;
								result_q        <= '0;
								result_q.status <= ST_CLEARED;
							end
							default: begin
								done_q            <= 1'b1;
								result_q          <= '0;
								result_q.status   <= ST_IGNORED;
								result_q.ap_total <= 5'(ap_count_q);
							end
						endcase
					end
				end
				S_AP_SCAN: begin
					scan_ptr_q <= scan_ptr_q + AP_IDX_W'(1);
					if (ap_hit) begin
						if (cur_q.kind == JOB_BEACON) begin
							done_q            <= 1'b1;
							result_q          <= '0;
							result_q.status   <= ST_AP_UPD;
							result_q.ap_slot  <= 4'(ap_rd_idx_s1);
							result_q.ap_total <= 5'(ap_count_q);
							state_q           <= S_IDLE;
						end else begin
							ap_sel_q   <= ap_rd_idx_s1;
							sta_base_q <= STA_ADDR_W'(32'(ap_rd_idx_s1) * MAX_STAS);
							sta_n_q    <= sta_cnt_rd_s1;
							sta_ptr_q  <= '0;
							state_q    <= (sta_cnt_rd_s1 == '0) ? S_STA_ADD : S_STA_SCAN;
						end
					end else if (ap_last) begin
						state_q <= S_AP_ADD;
					end
				end
				S_AP_ADD: begin
					done_q            <= 1'b1;
					result_q          <= '0;
					result_q.ap_total <= 5'(ap_count_q);
					state_q           <= S_IDLE;
					if (cur_q.kind != JOB_BEACON || !cur_q.new_ok) begin
						result_q.status <= ST_IGNORED;
					end else if (ap_full) begin
						result_q.status <= ST_FULL;
					end else begin
						result_q.status   <= ST_AP_NEW;
						result_q.ap_slot  <= 4'(ap_count_q);
						result_q.ap_total <= 5'(ap_count_q + AP_CNT_W'(1));
						ap_count_q        <= ap_count_q + AP_CNT_W'(1);
					end
				end
				S_STA_SCAN: begin
					sta_ptr_q <= sta_ptr_q + STA_IDX_W'(1);
					if (sta_hit) begin
						done_q            <= 1'b1;
						result_q          <= '0;
						result_q.status   <= ST_STA_UPD;
						result_q.ap_slot  <= 4'(ap_sel_q);
						result_q.sta_slot <= 3'(sta_rd_idx_s1);
						result_q.ap_total <= 5'(ap_count_q);
						state_q           <= S_IDLE;
					end else if (sta_last) begin
						state_q <= S_STA_ADD;
					end
				end
				S_STA_ADD: begin
					done_q            <= 1'b1;
					result_q          <= '0;
					result_q.ap_slot  <= 4'(ap_sel_q);
					result_q.ap_total <= 5'(ap_count_q);
					state_q           <= S_IDLE;
					if (sta_full) begin
						result_q.status <= ST_FULL;
					end else begin
						result_q.status   <= ST_STA_NEW;
						result_q.sta_slot <= 3'(sta_n_q);
					end
				end
				S_READ: begin
					done_q                   <= 1'b1;
					result_q                 <= '0;
					result_q.status          <= ST_READ_OK;
					result_q.ap_slot         <= cur_q.read_index;
					result_q.ap_total        <= 5'(ap_count_q);
					result_q.entry_bssid     <= ap_bssid_rd_s1;
					result_q.entry_channel   <= ap_chan_rd_s1;
					result_q.entry_rssi      <= ap_rssi_rd_s1;
					result_q.entry_sta_total <= 4'(sta_cnt_rd_s1);
					state_q                  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ap_count_q) <= MAX_APS)
		else $error("AP count above table size");

	a_ap_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AP_SCAN) |-> (ap_count_q != '0))
		else $error("AP scan with empty table");

	a_sta_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STA_SCAN) |-> (sta_n_q != '0))
		else $error("station scan with empty list");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status == ST_CLEARED) |-> (ap_count_q == '0))
		else $error("clear result with nonzero AP count");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |=> (done_q || state_q != S_IDLE))
		else $error("job taken without result or work");
`endif

endmodule

@@ src/ap_station_association_table.sv @@
// ----------------------------------------------------------------------------
// ap_station_association_table: two-level AP / station learning table
// Command channel: a transaction is taken at a clock edge with start high and
// busy low; cmd carries the operation and parsed frame fields.
// Result channel: done is high for one cycle with result valid; every
// command gives exactly one result, in order, and must be taken then.
// A two-deep job queue sits between intake and the table engine, so busy
// rises only when two commands are waiting behind the one in progress.
// Ignore, clear and bad-index reads are answered from the idle state and a
// good read after the registered memory read; a beacon scans the AP memory
// and a data frame scans it and then the station memory of the matched AP,
// one entry per cycle, until a match or the end of the list.
// Reset empties the table and the queue; no memory clearing pass is run.
// ----------------------------------------------------------------------------
module ap_station_association_table
	import apsat_pkg::*;
#(
	parameter int MAX_APS  = DEFAULT_MAX_APS,
	parameter int MAX_STAS = DEFAULT_MAX_STAS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	logic job_valid;
	logic job_pop;
	job_t job;

	apsat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job)
	);

	apsat_back #(
		.MAX_APS  (MAX_APS),
		.MAX_STAS (MAX_STAS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop),
		.done      (done),
		.result    (result)
	);

endmodule
